### sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define QAMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qams check failed");

// next-cycle implication, sampled on clk, off during reset
`define QAMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qams check failed");

`endif

### sv/qams_pkg.sv
package qams_pkg;

	// queue geometry and item layout
	localparam int QAMS_QUEUE_SLOTS = 8;
	localparam int QAMS_MSG_W       = 36;
	localparam int QAMS_ITEM_W      = 60;

	// item kinds carried on tuser
	localparam logic ACT_ENQ  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// message types
	localparam logic [3:0] MT_ANIMAL   = 4'd0;
	localparam logic [3:0] MT_PRODUCTS = 4'd1;
	localparam logic [3:0] MT_SE       = 4'd2;
	localparam logic [3:0] MT_MR       = 4'd3;
	localparam logic [3:0] MT_F        = 4'd4;
	localparam logic [3:0] MT_MU       = 4'd5;
	localparam logic [3:0] MT_MD       = 4'd6;
	localparam logic [3:0] MT_ML       = 4'd7;
	localparam logic [3:0] MT_SS       = 4'd8;
	localparam logic [3:0] MT_SU       = 4'd9;

	// ascii characters
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_F      = 8'h46;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_U      = 8'h55;
	localparam logic [7:0] CH_V      = 8'h56;

	// queue control and status between top and queue
	typedef struct packed {
		logic                   enq;
		logic                   deq;
		logic [QAMS_ITEM_W-1:0] item;
	} q_cmd_t;

	typedef struct packed {
		logic nonempty;
		logic enq_ok;
		logic space_after;
	} q_stat_t;

	// characters produced by one serializer tick
	typedef struct packed {
		logic       emit;
		logic       two;
		logic [7:0] c0;
		logic [7:0] c1;
	} ser_res_t;

	// pack an enqueue item into a stored message
	function automatic logic [QAMS_MSG_W-1:0] pack_msg(input logic [QAMS_ITEM_W-1:0] it);
		logic [3:0] mt;
		begin
			mt = it[3:0];
			if (mt == MT_ANIMAL) begin
				return {8'h00, it[27:4], mt};
			end else if (mt == MT_PRODUCTS) begin
				return {it[59:28], mt};
			end
			return {32'h0, mt};
		end
	endfunction

	// hundreds, tens, ones of an 8-bit value, one nibble each
	function automatic logic [11:0] to_bcd(input logic [7:0] v);
		logic [1:0]  h;
		logic [6:0]  u;
		logic [14:0] p;
		logic [3:0]  t;
		logic [3:0]  o;
		begin
			if (v >= 8'd200) begin
				h = 2'd2;
				u = 7'(v - 8'd200);
			end else if (v >= 8'd100) begin
				h = 2'd1;
				u = 7'(v - 8'd100);
			end else begin
				h = 2'd0;
				u = v[6:0];
			end
			// divide by ten through the reciprocal, exact below 100
			p = 15'(u) * 15'd205;
			t = p[14:11];
			o = 4'(u - 7'(t) * 7'd10);
			return {2'b00, h, t, o};
		end
	endfunction

	// character of a fixed command string, zero past its end
	function automatic logic [7:0] fixed_char(input logic [3:0] mt, input logic [2:0] ci);
		logic [7:0] l1;
		logic [7:0] l2;
		begin
			l1 = CH_S;
			l2 = CH_E;
			case (mt)
				MT_SE: begin l1 = CH_S; l2 = CH_E; end
				MT_MR: begin l1 = CH_M; l2 = CH_R; end
				MT_MU: begin l1 = CH_M; l2 = CH_U; end
				MT_MD: begin l1 = CH_M; l2 = CH_D; end
				MT_ML: begin l1 = CH_M; l2 = CH_L; end
				MT_SS: begin l1 = CH_S; l2 = CH_S; end
				MT_SU: begin l1 = CH_S; l2 = CH_U; end
				default: begin l1 = CH_F; l2 = CH_CR; end
			endcase
			if (mt == MT_F) begin
				case (ci)
					3'd0: return CH_F;
					3'd1: return CH_CR;
					3'd2: return CH_LF;
					default: return 8'h00;
				endcase
			end
			case (ci)
				3'd0: return l1;
				3'd1: return l2;
				3'd2: return CH_CR;
				3'd3: return CH_LF;
				default: return 8'h00;
			endcase
		end
	endfunction

	// animal kind letter
	function automatic logic [7:0] kind_char(input logic [7:0] k);
		begin
			case (k)
				8'd1: return CH_P;
				8'd2: return CH_C;
				8'd3: return CH_G;
				default: return CH_V;
			endcase
		end
	endfunction

endpackage

### sv/qams_ram.sv
module qams_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/qams_queue.sv
module qams_queue import qams_pkg::*; #(
	parameter int QUEUE_SLOTS = QAMS_QUEUE_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_cmd_t                cmd,
	output q_stat_t               stat,
	output logic [QAMS_MSG_W-1:0] rd_data
);

	localparam int PW = $clog2(QUEUE_SLOTS);
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);

	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW-1:0] wp_inc;
	logic [PW-1:0] wp_inc2;
	logic [PW-1:0] rp_inc;
	logic          do_enq;
	logic          do_deq;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : PW'(p + 1'b1);
	endfunction

	// ring pointer arithmetic
	always_comb begin
		wp_inc  = next_slot(wp_q);
		wp_inc2 = next_slot(wp_inc);
		rp_inc  = next_slot(rp_q);
		stat.nonempty = (rp_q != wp_q);
		stat.enq_ok   = (wp_inc != rp_q);
		do_enq = cmd.enq && stat.enq_ok;
		do_deq = cmd.deq && stat.nonempty;
		// space as seen after this transfer
		if (do_enq) begin
			stat.space_after = (wp_inc2 != rp_q);
		end else if (do_deq) begin
			stat.space_after = (wp_inc != rp_inc);
		end else begin
			stat.space_after = (wp_inc != rp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (do_enq) begin
				wp_q <= wp_inc;
			end
			if (do_deq) begin
				rp_q <= rp_inc;
			end
		end
	end

	// message store
	qams_ram #(
		.WIDTH(QAMS_MSG_W),
		.DEPTH(QUEUE_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (do_enq),
		.waddr(wp_q),
		.wdata(pack_msg(cmd.item)),
		.re   (do_deq),
		.raddr(rp_q),
		.rdata(rd_data)
	);

endmodule

### sv/qams_ser.sv
module qams_ser import qams_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick,
	input  logic                  load,
	input  logic [QAMS_MSG_W-1:0] load_msg,
	output logic                  busy,
	output ser_res_t              res
);

	logic [QAMS_MSG_W-1:0] cm_q;
	logic [2:0]            fs_q;
	logic [2:0]            ci_q;
	logic [11:0]           dd_q;
	logic                  busy_q;

	logic [QAMS_MSG_W-1:0] cm_n;
	logic [2:0]            fs_n;
	logic [2:0]            ci_n;
	logic [11:0]           dd_n;
	logic                  busy_n;

	logic [3:0]  mt;
	logic [7:0]  num_v;
	logic [11:0] bcd;
	logic [2:0]  ci_eff;
	logic [11:0] dd_eff;
	logic [3:0]  digit;
	logic        num_done;
	logic [7:0]  fx;

	assign busy = busy_q;

	// decimal field path shared by every number
	always_comb begin
		mt = cm_q[3:0];
		if (mt == MT_ANIMAL) begin
			num_v = cm_q[19:12];
		end else begin
			case (fs_q)
				3'd1: num_v = cm_q[11:4];
				3'd2: num_v = cm_q[19:12];
				3'd3: num_v = cm_q[27:20];
				default: num_v = cm_q[35:28];
			endcase
		end
		bcd = to_bcd(num_v);
		if (ci_q == 3'd0) begin
			dd_eff = bcd;
			if (bcd[11:8] != 4'd0) begin
				ci_eff = 3'd1;
			end else if (bcd[7:4] != 4'd0) begin
				ci_eff = 3'd2;
			end else begin
				ci_eff = 3'd3;
			end
		end else begin
			dd_eff = dd_q;
			ci_eff = ci_q;
		end
		case (ci_eff)
			3'd1: digit = dd_eff[11:8];
			3'd2: digit = dd_eff[7:4];
			default: digit = dd_eff[3:0];
		endcase
		num_done = (ci_eff < 3'd1) || (ci_eff > 3'd3);
		fx = fixed_char(mt, ci_q);
	end

	// one tick of the message sequencer
	always_comb begin
		cm_n   = cm_q;
		fs_n   = fs_q;
		ci_n   = ci_q;
		dd_n   = dd_q;
		busy_n = busy_q;
		res    = '0;
		if (load) begin
			cm_n   = load_msg;
			fs_n   = 3'd0;
			ci_n   = 3'd0;
			busy_n = 1'b1;
		end else if (tick) begin
			if (mt >= MT_SE) begin
				// fixed command strings
				if (mt <= MT_SU && ci_q < 3'd5 && fx != 8'h00) begin
					res.emit = 1'b1;
					res.c0   = fx;
					ci_n     = 3'(ci_q + 1'b1);
				end else begin
					busy_n = 1'b0;
					fs_n   = 3'd0;
					ci_n   = 3'd0;
				end
			end else if (fs_q == 3'd0) begin
				// record head, then one idle tick
				if (ci_q < 3'd3) begin
					res.emit = 1'b1;
					case (ci_q)
						3'd0: res.c0 = CH_D;
						3'd1: res.c0 = (mt == MT_ANIMAL) ? CH_A : CH_P;
						default: res.c0 = CH_COLON;
					endcase
					ci_n = 3'(ci_q + 1'b1);
				end else begin
					ci_n = 3'd0;
					fs_n = 3'd1;
				end
			end else if (mt == MT_ANIMAL && fs_q == 3'd1) begin
				res.emit = 1'b1;
				res.c0   = kind_char(cm_q[11:4]);
				fs_n     = 3'd2;
			end else if (mt == MT_ANIMAL && fs_q == 3'd2) begin
				res.emit = 1'b1;
				res.c0   = CH_DOLLAR;
				fs_n     = 3'd3;
			end else if (mt == MT_ANIMAL && fs_q == 3'd4) begin
				// status letter and line end, then one idle tick
				if (ci_q < 3'd3) begin
					res.emit = 1'b1;
					case (ci_q)
						3'd0: res.c0 = (cm_q[27:20] == 8'd0) ? CH_A : CH_S;
						3'd1: res.c0 = CH_CR;
						default: res.c0 = CH_LF;
					endcase
					ci_n = 3'(ci_q + 1'b1);
				end else begin
					busy_n = 1'b0;
					fs_n   = 3'd0;
					ci_n   = 3'd0;
				end
			end else if ((mt == MT_ANIMAL && fs_q == 3'd3) ||
				(mt == MT_PRODUCTS && fs_q <= 3'd4)) begin
				// decimal number, then its separator
				res.emit = 1'b1;
				if (!num_done) begin
					res.c0 = CH_ZERO + 8'(digit);
					ci_n   = 3'(ci_eff + 1'b1);
					dd_n   = dd_eff;
				end else begin
					ci_n = 3'd0;
					dd_n = dd_eff;
					if (mt == MT_PRODUCTS && fs_q == 3'd4) begin
						res.two = 1'b1;
						res.c0  = CH_CR;
						res.c1  = CH_LF;
						busy_n  = 1'b0;
						fs_n    = 3'd0;
					end else begin
						res.c0 = CH_DOLLAR;
						fs_n   = 3'(fs_q + 1'b1);
					end
				end
			end else begin
				busy_n = 1'b0;
				fs_n   = 3'd0;
				ci_n   = 3'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= 3'd0;
			ci_q   <= 3'd0;
			busy_q <= 1'b0;
			dd_q   <= '0;
			cm_q   <= '0;
		end else begin
			fs_q   <= fs_n;
			ci_q   <= ci_n;
			busy_q <= busy_n;
			dd_q   <= dd_n;
			cm_q   <= cm_n;
		end
	end

endmodule

### sv/queued_ascii_message_serializer.sv
// Queued ASCII message serializer. Input transfers with s_tuser low enqueue a
// message into a ring queue of QUEUE_SLOTS-1 usable slots; with s_tuser high
// they are transmitter-ready ticks, each of which either takes the oldest
// message when none is being sent or advances the one being sent. Every input
// transfer gives one output transfer, except the tick that closes a products
// record, which gives CR and then LF (m_tlast low on the CR). A tick that takes
// a message from the queue holds the input while the message loads through the
// registered read port of the queue memory, and the closing CR LF tick holds
// the input for the extra output transfer. A new item is taken in the cycle a
// waiting result leaves the output register.
module queued_ascii_message_serializer import qams_pkg::*; #(
	parameter int QUEUE_SLOTS = QAMS_QUEUE_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// msg_type[3:0], animal_kind[11:4], animal_number[19:12],
	// animal_status[27:20], count_milk[35:28], count_ham[43:36],
	// count_eggs[51:44], count_brush[59:52], zero[63:60]
	input  logic [63:0] s_tdata,
	// action[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tx_char[7:0], enqueue_accepted[8], queue_has_space[9], zero[15:10]
	output logic [15:0] m_tdata,
	// char_valid[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_PEND = 3'b100
	} st_t;

	st_t st_q;
	st_t st_n;

	logic                  acc;
	logic                  is_tick;
	logic                  busy;
	logic                  fire;
	q_cmd_t                qcmd;
	q_stat_t               qstat;
	logic [QAMS_MSG_W-1:0] rd_msg;
	ser_res_t              res;

	logic       m_tvalid_q;
	logic [7:0] char_q;
	logic       cvalid_q;
	logic       enq_ok_q;
	logic       space_q;
	logic       last_q;
	logic [7:0] lf_q;

	assign s_tready = (st_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;
	assign is_tick  = (s_tuser == ACT_TICK);
	assign fire     = acc && is_tick && busy;

	// queue command for this transfer
	always_comb begin
		qcmd.enq  = acc && !is_tick;
		qcmd.deq  = acc && is_tick && !busy;
		qcmd.item = s_tdata[QAMS_ITEM_W-1:0];
	end

	qams_queue #(
		.QUEUE_SLOTS(QUEUE_SLOTS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qcmd),
		.stat   (qstat),
		.rd_data(rd_msg)
	);

	qams_ser u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (fire),
		.load    (st_q == ST_LOAD),
		.load_msg(rd_msg),
		.busy    (busy),
		.res     (res)
	);

	// item sequencing
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (qcmd.deq && qstat.nonempty) begin
					st_n = ST_LOAD;
				end else if (fire && res.two) begin
					st_n = ST_PEND;
				end
			end
			ST_LOAD: st_n = ST_IDLE;
			ST_PEND: begin
				if (m_tready) begin
					st_n = ST_IDLE;
				end
			end
			default: st_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (acc || st_q == ST_PEND) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// output register payload, second character held for the closing line feed
	always_ff @(posedge clk) begin
		if (acc) begin
			cvalid_q <= fire && res.emit;
			char_q   <= (fire && res.emit) ? res.c0 : 8'h00;
			enq_ok_q <= qcmd.enq && qstat.enq_ok;
			space_q  <= qstat.space_after;
			last_q   <= !(fire && res.two);
			lf_q     <= res.c1;
		end else if (st_q == ST_PEND && m_tready) begin
			char_q <= lf_q;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b000000, space_q, enq_ok_q, char_q};
	assign m_tuser  = cvalid_q;
	assign m_tlast  = last_q;

endmodule

### sv/qams_chk.sv
`include "assert_macros.svh"

module qams_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled result stays offered
	`QAMS_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid)

	// an accepted enqueue answer carries no character
	`QAMS_ASSERT_IMP(a_enq_nochar, m_tvalid && m_tdata[8], !m_tuser && m_tdata[7:0] == 8'h00)

	// only the carriage return of a closing line end is a non-final result
	`QAMS_ASSERT_IMP(a_cr_first, m_tvalid && !m_tlast, m_tuser && m_tdata[7:0] == 8'h0D)

	// a taken carriage return is followed at once by the final line feed
	`QAMS_ASSERT_NXT(a_lf_next, m_tvalid && m_tready && !m_tlast,
		m_tvalid && m_tlast && m_tdata[7:0] == 8'h0A)

	// no new item is taken while the line feed is still owed
	`QAMS_ASSERT_IMP(a_no_take, m_tvalid && !m_tlast, !s_tready)

endmodule

bind queued_ascii_message_serializer qams_chk u_chk (.*);
